// ===== sv/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg: shared types and constants for the lost packet crossfade
// Holds the packet geometry, the datapath widths that follow from it, the
// divider reciprocal and the structs that travel between the modules.
// ----------------------------------------------------------------------------
package lpc_pkg;

   localparam int SAMPLES_PER_PACKET = 348;
   localparam int SPAN               = SAMPLES_PER_PACKET - 1;
   localparam int POS_W              = $clog2(SAMPLES_PER_PACKET);

   localparam int SMP_W   = 16;
   localparam int FLD_W   = 16;
   localparam int NUM_W   = POS_W + SMP_W + 1;
   localparam int ABS_W   = NUM_W - 1;
   localparam int SHIFT   = ABS_W;
   localparam int RCP_W   = SHIFT + 1;
   localparam int QUO_W   = SMP_W + 1;

   localparam logic [RCP_W-1:0]        RECIP      = RCP_W'((64'd1 << SHIFT) / SPAN);
   localparam logic [ABS_W-1:0]        SPAN_ABS   = ABS_W'(SPAN);
   localparam logic signed [NUM_W-1:0] SPAN_NUM   = NUM_W'(SPAN);
   localparam logic [POS_W-1:0]        SPAN_POS   = POS_W'(SPAN);

   typedef enum logic {
      OP_HEADER = 1'b0,
      OP_SAMPLE = 1'b1
   } lpc_op_type;

   typedef struct packed {
      logic ld0;
      logic ld1;
      logic ld2;
      logic ld3;
   } lpc_step_type;

   typedef struct packed {
      logic             kind;
      logic             last;
      logic [FLD_W-1:0] count;
      logic [FLD_W-1:0] seq;
      logic [FLD_W-1:0] stamp;
   } lpc_side_type;

endpackage

// ===== sv/lpc_mix.sv =====
// ----------------------------------------------------------------------------
// lpc_mix: one channel of the crossfade datapath
// Forms prev*(N-1-i) + next*i, then divides by N-1 toward zero with a
// reciprocal multiply and a single remainder correction.
// ----------------------------------------------------------------------------
module lpc_mix (
   input  logic                              clock,
   input  lpc_pkg::lpc_step_type             step,
   input  logic signed [lpc_pkg::SMP_W-1:0]  prev,
   input  logic signed [lpc_pkg::SMP_W-1:0]  next,
   input  logic        [lpc_pkg::POS_W-1:0]  pos,
   output logic signed [lpc_pkg::SMP_W-1:0]  mixed
);

   logic signed [lpc_pkg::SMP_W:0]                      diff;
   logic signed [lpc_pkg::POS_W:0]                      pos_s;
   logic signed [lpc_pkg::NUM_W-1:0]                    num_in, num_ff;
   logic                                                neg_in, neg_ff;
   logic        [lpc_pkg::ABS_W-1:0]                    abs_in, abs_ff;
   logic        [lpc_pkg::ABS_W+lpc_pkg::RCP_W-1:0]     prod_in, prod_ff;
   logic        [lpc_pkg::QUO_W-1:0]                    quo_est, quo;
   logic        [lpc_pkg::ABS_W-1:0]                    rem;
   logic signed [lpc_pkg::SMP_W-1:0]                    mixed_in, mixed_ff;

   always_comb begin
      diff   = {next[lpc_pkg::SMP_W-1], next} - {prev[lpc_pkg::SMP_W-1], prev};
      pos_s  = {1'b0, pos};
      num_in = lpc_pkg::NUM_W'(diff) * lpc_pkg::NUM_W'(pos_s)
             + lpc_pkg::NUM_W'(prev) * lpc_pkg::SPAN_NUM;
   end

   always_comb begin
      neg_in  = num_ff[lpc_pkg::NUM_W-1];
      abs_in  = neg_in ? lpc_pkg::ABS_W'(-num_ff) : lpc_pkg::ABS_W'(num_ff);
      prod_in = lpc_pkg::ABS_W'(abs_in) * lpc_pkg::RECIP;
   end

   always_comb begin
      quo_est = prod_ff[lpc_pkg::SHIFT +: lpc_pkg::QUO_W];
      rem     = abs_ff - lpc_pkg::ABS_W'(quo_est * lpc_pkg::SPAN_ABS);
      quo     = (rem >= lpc_pkg::SPAN_ABS) ? quo_est + 1'b1 : quo_est;
      mixed_in = neg_ff ? lpc_pkg::SMP_W'(-quo) : lpc_pkg::SMP_W'(quo);
   end

   always_ff @(posedge clock) begin
      if (step.ld1) begin
         num_ff <= num_in;
      end
      if (step.ld2) begin
         neg_ff  <= neg_in;
         abs_ff  <= abs_in;
         prod_ff <= prod_in;
      end
      if (step.ld3) begin
         mixed_ff <= mixed_in;
      end
   end

   assign mixed = mixed_ff;

endmodule

// ===== sv/lpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpc_ctrl: pipeline occupancy and sample position
// Tracks the four stage valid bits, builds the stall chain and advances the
// position on each accepted sample; a header or the final sample clears it.
// ----------------------------------------------------------------------------
module lpc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_op,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output lpc_pkg::lpc_step_type        step,
   output logic [lpc_pkg::POS_W-1:0]    pos,
   output logic                         fin
);

   logic [3:0]                  vld_ff, vld_in;
   logic [3:0]                  rdy;
   logic [lpc_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        accept;

   always_comb begin
      rdy[3] = !vld_ff[3] || !rsp_stall;
      rdy[2] = !vld_ff[2] || rdy[3];
      rdy[1] = !vld_ff[1] || rdy[2];
      rdy[0] = !vld_ff[0] || rdy[1];
   end

   always_comb begin
      step.ld0 = rdy[0] && req_valid;
      step.ld1 = rdy[1] && vld_ff[0];
      step.ld2 = rdy[2] && vld_ff[1];
      step.ld3 = rdy[3] && vld_ff[2];
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      vld_in[1] = rdy[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = rdy[2] ? vld_ff[1] : vld_ff[2];
      vld_in[3] = rdy[3] ? vld_ff[2] : vld_ff[3];
   end

   always_comb begin
      accept = req_valid && rdy[0];
      fin    = pos_ff >= lpc_pkg::SPAN_POS;
      pos_in = pos_ff;
      if (accept) begin
         if (req_op == lpc_pkg::OP_HEADER || fin) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         pos_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         pos_ff <= pos_in;
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[3];
   assign pos       = pos_ff;

   a_header_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == lpc_pkg::OP_HEADER |=> pos_ff == '0)
      else $error("position not cleared by header request");

   a_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == lpc_pkg::OP_SAMPLE && fin |=> pos_ff == '0)
      else $error("position did not wrap after final sample");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == lpc_pkg::OP_SAMPLE && !fin
      |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("position did not advance");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> vld_ff == 4'b1111)
      else $error("request stalled with a free stage");

endmodule

// ===== sv/lost_packet_crossfade.sv =====
// ----------------------------------------------------------------------------
// lost_packet_crossfade: rebuild a lost stereo packet by linear crossfade
// Header requests give the rebuilt header; sample requests blend previous
// and next stereo samples by position within the packet.
// ----------------------------------------------------------------------------
//   channel  | handshake              | payload
//   req      | req_valid / req_stall  | op, header fields, four samples
//   rsp      | rsp_valid / rsp_stall  | kind, header fields, two mixes, last
//
// One request per cycle sustained while rsp_stall is low; results pass
// through the input, product, reciprocal and result registers.
// The divider multiply and its remainder correction set the stage split.
// Reset clears the stage valid bits and the sample position.
// A stalled result holds; requests are taken until all four stages are full.
// ----------------------------------------------------------------------------
module lost_packet_crossfade (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic        [lpc_pkg::FLD_W-1:0]   req_prev_count,
   input  logic        [lpc_pkg::FLD_W-1:0]   req_prev_seq,
   input  logic        [lpc_pkg::FLD_W-1:0]   req_prev_stamp,
   input  logic        [lpc_pkg::FLD_W-1:0]   req_next_stamp,
   input  logic signed [lpc_pkg::SMP_W-1:0]   req_prev_left,
   input  logic signed [lpc_pkg::SMP_W-1:0]   req_prev_right,
   input  logic signed [lpc_pkg::SMP_W-1:0]   req_next_left,
   input  logic signed [lpc_pkg::SMP_W-1:0]   req_next_right,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_kind,
   output logic        [lpc_pkg::FLD_W-1:0]   rsp_out_count,
   output logic        [lpc_pkg::FLD_W-1:0]   rsp_out_seq,
   output logic        [lpc_pkg::FLD_W-1:0]   rsp_out_stamp,
   output logic signed [lpc_pkg::SMP_W-1:0]   rsp_mixed_left,
   output logic signed [lpc_pkg::SMP_W-1:0]   rsp_mixed_right,
   output logic                               rsp_last
);

   lpc_pkg::lpc_step_type               step;
   logic [lpc_pkg::POS_W-1:0]           pos;
   logic                                fin;

   logic                                op_ff;
   logic                                fin_ff;
   logic [lpc_pkg::POS_W-1:0]           pos_ff;
   logic [lpc_pkg::FLD_W-1:0]           count_ff, seq_ff, pstamp_ff, nstamp_ff;
   logic signed [lpc_pkg::SMP_W-1:0]    pl_ff, pr_ff, nl_ff, nr_ff;

   lpc_pkg::lpc_side_type               side1_in, side1_ff, side2_ff, side3_ff;
   logic signed [lpc_pkg::SMP_W-1:0]    mix_left, mix_right;

   lpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .step      (step),
      .pos       (pos),
      .fin       (fin)
   );

   always_ff @(posedge clock) begin
      if (step.ld0) begin
         op_ff     <= req_op;
         fin_ff    <= fin;
         pos_ff    <= (req_op == lpc_pkg::OP_HEADER) ? '0 : pos;
         count_ff  <= req_prev_count;
         seq_ff    <= req_prev_seq;
         pstamp_ff <= req_prev_stamp;
         nstamp_ff <= req_next_stamp;
         pl_ff     <= req_prev_left;
         pr_ff     <= req_prev_right;
         nl_ff     <= req_next_left;
         nr_ff     <= req_next_right;
      end
   end

   always_comb begin
      side1_in = '0;
      side1_in.kind = op_ff;
      if (op_ff == lpc_pkg::OP_HEADER) begin
         side1_in.count = count_ff;
         side1_in.seq   = seq_ff + 1'b1;
         side1_in.stamp = (pstamp_ff >> 1) + (nstamp_ff >> 1);
      end else begin
         side1_in.last  = fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step.ld1) begin
         side1_ff <= side1_in;
      end
      if (step.ld2) begin
         side2_ff <= side1_ff;
      end
      if (step.ld3) begin
         side3_ff <= side2_ff;
      end
   end

   lpc_mix u_mix_left (
      .clock (clock),
      .step  (step),
      .prev  (pl_ff),
      .next  (nl_ff),
      .pos   (pos_ff),
      .mixed (mix_left)
   );

   lpc_mix u_mix_right (
      .clock (clock),
      .step  (step),
      .prev  (pr_ff),
      .next  (nr_ff),
      .pos   (pos_ff),
      .mixed (mix_right)
   );

   assign rsp_kind        = side3_ff.kind;
   assign rsp_out_count   = side3_ff.count;
   assign rsp_out_seq     = side3_ff.seq;
   assign rsp_out_stamp   = side3_ff.stamp;
   assign rsp_last        = side3_ff.last;
   assign rsp_mixed_left  = side3_ff.kind ? mix_left  : '0;
   assign rsp_mixed_right = side3_ff.kind ? mix_right : '0;

endmodule

// ===== bench/crossfade_checker.sv =====
// ----------------------------------------------------------------------------
// crossfade_checker: result scoreboard for the lost packet crossfade
// Watches both channels and keeps its own copy of the packet position. Every
// accepted request becomes an expected header or blended stereo pair, which
// is compared field by field with the next accepted result. It counts
// mismatches and hands the count back to the bench top.
// ----------------------------------------------------------------------------
module crossfade_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_op,
   input  logic        [lpc_pkg::FLD_W-1:0]   req_prev_count,
   input  logic        [lpc_pkg::FLD_W-1:0]   req_prev_seq,
   input  logic        [lpc_pkg::FLD_W-1:0]   req_prev_stamp,
   input  logic        [lpc_pkg::FLD_W-1:0]   req_next_stamp,
   input  logic signed [lpc_pkg::SMP_W-1:0]   req_prev_left,
   input  logic signed [lpc_pkg::SMP_W-1:0]   req_prev_right,
   input  logic signed [lpc_pkg::SMP_W-1:0]   req_next_left,
   input  logic signed [lpc_pkg::SMP_W-1:0]   req_next_right,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_kind,
   input  logic        [lpc_pkg::FLD_W-1:0]   rsp_out_count,
   input  logic        [lpc_pkg::FLD_W-1:0]   rsp_out_seq,
   input  logic        [lpc_pkg::FLD_W-1:0]   rsp_out_stamp,
   input  logic signed [lpc_pkg::SMP_W-1:0]   rsp_mixed_left,
   input  logic signed [lpc_pkg::SMP_W-1:0]   rsp_mixed_right,
   input  logic                               rsp_last,
   output int                                 failures,
   output int                                 outstanding,
   output int                                 headers_seen,
   output int                                 samples_seen,
   output int                                 packet_ends,
   output int                                 results_checked
);

   typedef struct {
      lpc_pkg::lpc_op_type                kind;
      logic [lpc_pkg::FLD_W-1:0]          count;
      logic [lpc_pkg::FLD_W-1:0]          seq;
      logic [lpc_pkg::FLD_W-1:0]          stamp;
      logic signed [lpc_pkg::SMP_W-1:0]   left;
      logic signed [lpc_pkg::SMP_W-1:0]   right;
      logic                               last;
   } rebuilt_item_type;

   rebuilt_item_type rebuilt_q[$];
   int unsigned      fade_pos;

   function automatic logic signed [lpc_pkg::SMP_W-1:0] fade_mix(
         logic signed [lpc_pkg::SMP_W-1:0] from_prev,
         logic signed [lpc_pkg::SMP_W-1:0] to_next,
         int unsigned at);
      longint span;
      longint acc;
      span = lpc_pkg::SAMPLES_PER_PACKET - 1;
      acc  = longint'(from_prev) * (span - longint'(at))
           + longint'(to_next) * longint'(at);
      return lpc_pkg::SMP_W'(acc / span);
   endfunction

   function automatic rebuilt_item_type rebuild_packet_item();
      rebuilt_item_type item;
      item.kind  = lpc_pkg::lpc_op_type'(req_op);
      item.count = '0;
      item.seq   = '0;
      item.stamp = '0;
      item.left  = '0;
      item.right = '0;
      item.last  = 1'b0;
      if (req_op == lpc_pkg::OP_HEADER) begin
         item.count = req_prev_count;
         item.seq   = req_prev_seq + 16'd1;
         item.stamp = (req_prev_stamp >> 1) + (req_next_stamp >> 1);
         fade_pos   = 0;
      end else begin
         item.left  = fade_mix(req_prev_left, req_next_left, fade_pos);
         item.right = fade_mix(req_prev_right, req_next_right, fade_pos);
         item.last  = (fade_pos >= lpc_pkg::SAMPLES_PER_PACKET - 1);
         fade_pos   = item.last ? 0 : fade_pos + 1;
      end
      return item;
   endfunction

   task automatic report(string msg);
      if (failures < 25)
         $display("ERROR: %s", msg);
      failures++;
   endtask

   task automatic check_field(string name, logic [lpc_pkg::FLD_W-1:0] want,
                              logic [lpc_pkg::FLD_W-1:0] got);
      if (got !== want)
         report($sformatf("result %0d %s: expected %h, got %h",
                          results_checked, name, want, got));
   endtask

   always @(posedge clock) begin : watch
      rebuilt_item_type want;
      if (reset) begin
         rebuilt_q.delete();
         fade_pos = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (rsp_kind == lpc_pkg::OP_SAMPLE && rsp_last)
               packet_ends++;
            if (rebuilt_q.size() == 0) begin
               report($sformatf("result %0d arrived with nothing pending", results_checked));
            end else begin
               want = rebuilt_q.pop_front();
               check_field("kind", lpc_pkg::FLD_W'(want.kind), lpc_pkg::FLD_W'(rsp_kind));
               check_field("out_count", want.count, rsp_out_count);
               check_field("out_seq", want.seq, rsp_out_seq);
               check_field("out_stamp", want.stamp, rsp_out_stamp);
               check_field("mixed_left", want.left, rsp_mixed_left);
               check_field("mixed_right", want.right, rsp_mixed_right);
               check_field("last", lpc_pkg::FLD_W'(want.last), lpc_pkg::FLD_W'(rsp_last));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_op == lpc_pkg::OP_HEADER)
               headers_seen++;
            else
               samples_seen++;
            rebuilt_q.push_back(rebuild_packet_item());
         end
      end
      outstanding = rebuilt_q.size();
   end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for lost_packet_crossfade
// Sends directed header and sample requests at the field extremes, then
// random packets: headers followed by runs of samples, full packets that
// reach and pass the last position, stray samples and empty headers. The
// sender works in bursts and the receiver stalls on its own pattern,
// including long hold-offs that back the block up. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_ITEMS = 510;
   localparam int HOLD_CYCLES  = 90;
   localparam int LIMIT        = 200000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_op = 1'b0;
   logic [lpc_pkg::FLD_W-1:0]        req_prev_count = '0;
   logic [lpc_pkg::FLD_W-1:0]        req_prev_seq = '0;
   logic [lpc_pkg::FLD_W-1:0]        req_prev_stamp = '0;
   logic [lpc_pkg::FLD_W-1:0]        req_next_stamp = '0;
   logic signed [lpc_pkg::SMP_W-1:0] req_prev_left = '0;
   logic signed [lpc_pkg::SMP_W-1:0] req_prev_right = '0;
   logic signed [lpc_pkg::SMP_W-1:0] req_next_left = '0;
   logic signed [lpc_pkg::SMP_W-1:0] req_next_right = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_kind;
   logic [lpc_pkg::FLD_W-1:0]        rsp_out_count;
   logic [lpc_pkg::FLD_W-1:0]        rsp_out_seq;
   logic [lpc_pkg::FLD_W-1:0]        rsp_out_stamp;
   logic signed [lpc_pkg::SMP_W-1:0] rsp_mixed_left;
   logic signed [lpc_pkg::SMP_W-1:0] rsp_mixed_right;
   logic                             rsp_last;

   int failures;
   int outstanding;
   int headers_seen;
   int samples_seen;
   int packet_ends;
   int results_checked;

   int cycles = 0;
   int items_sent = 0;
   int burst_left = 0;
   bit hold_off = 1'b0;

   always #2 clock = ~clock;

   lost_packet_crossfade dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_prev_count  (req_prev_count),
      .req_prev_seq    (req_prev_seq),
      .req_prev_stamp  (req_prev_stamp),
      .req_next_stamp  (req_next_stamp),
      .req_prev_left   (req_prev_left),
      .req_prev_right  (req_prev_right),
      .req_next_left   (req_next_left),
      .req_next_right  (req_next_right),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_count   (rsp_out_count),
      .rsp_out_seq     (rsp_out_seq),
      .rsp_out_stamp   (rsp_out_stamp),
      .rsp_mixed_left  (rsp_mixed_left),
      .rsp_mixed_right (rsp_mixed_right),
      .rsp_last        (rsp_last)
   );

   crossfade_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_prev_count  (req_prev_count),
      .req_prev_seq    (req_prev_seq),
      .req_prev_stamp  (req_prev_stamp),
      .req_next_stamp  (req_next_stamp),
      .req_prev_left   (req_prev_left),
      .req_prev_right  (req_prev_right),
      .req_next_left   (req_next_left),
      .req_next_right  (req_next_right),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_count   (rsp_out_count),
      .rsp_out_seq     (rsp_out_seq),
      .rsp_out_stamp   (rsp_out_stamp),
      .rsp_mixed_left  (rsp_mixed_left),
      .rsp_mixed_right (rsp_mixed_right),
      .rsp_last        (rsp_last),
      .failures        (failures),
      .outstanding     (outstanding),
      .headers_seen    (headers_seen),
      .samples_seen    (samples_seen),
      .packet_ends     (packet_ends),
      .results_checked (results_checked)
   );

   function automatic logic [lpc_pkg::SMP_W-1:0] any_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return lpc_pkg::SMP_W'($urandom);
      endcase
   endfunction

   function automatic logic [lpc_pkg::FLD_W-1:0] any_field();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return lpc_pkg::FLD_W'($urandom);
      endcase
   endfunction

   task automatic send(lpc_pkg::lpc_op_type op,
                       logic [lpc_pkg::FLD_W-1:0] count, logic [lpc_pkg::FLD_W-1:0] seq,
                       logic [lpc_pkg::FLD_W-1:0] pstamp, logic [lpc_pkg::FLD_W-1:0] nstamp,
                       logic [lpc_pkg::SMP_W-1:0] pleft, logic [lpc_pkg::SMP_W-1:0] pright,
                       logic [lpc_pkg::SMP_W-1:0] nleft, logic [lpc_pkg::SMP_W-1:0] nright);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (!hold_off && gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
      end
      burst_left--;
      req_op         <= op;
      req_prev_count <= count;
      req_prev_seq   <= seq;
      req_prev_stamp <= pstamp;
      req_next_stamp <= nstamp;
      req_prev_left  <= pleft;
      req_prev_right <= pright;
      req_next_left  <= nleft;
      req_next_right <= nright;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_header();
      send(lpc_pkg::OP_HEADER, any_field(), any_field(), any_field(), any_field(),
           any_sample(), any_sample(), any_sample(), any_sample());
   endtask

   task automatic send_sample();
      send(lpc_pkg::OP_SAMPLE, any_field(), any_field(), any_field(), any_field(),
           any_sample(), any_sample(), any_sample(), any_sample());
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, outstanding);
         $display("** lost_packet_crossfade: FAILED **");
         $finish;
      end
   end

   initial begin : receiver
      int mode;
      int run_len;
      int phase;
      while (reset) @(posedge clock);
      for (phase = 0; ; phase++) begin
         if (phase == 3 || phase == 14) begin
            hold_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(10, 60);
            repeat (run_len) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ~rsp_stall;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : sender
      int target;
      int run_len;
      int choice;
      bit first_pass;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sample before any header, then header extremes
      send(lpc_pkg::OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
           16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      send(lpc_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
           16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
      send(lpc_pkg::OP_HEADER, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
           16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send(lpc_pkg::OP_HEADER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
           16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
      send(lpc_pkg::OP_HEADER, 16'h8000, 16'h7FFF, 16'h0001, 16'h0001,
           16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send(lpc_pkg::OP_HEADER, 16'h1234, 16'hFFFE, 16'hFFFF, 16'h0000,
           16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send(lpc_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
           16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send(lpc_pkg::OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
           16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send(lpc_pkg::OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
           16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send(lpc_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
           16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF);
      send(lpc_pkg::OP_SAMPLE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
           16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      send(lpc_pkg::OP_SAMPLE, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
           16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
      repeat (4) send_sample();
      send(lpc_pkg::OP_HEADER, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (3) send_sample();

      // random packets: full ones that wrap, short runs, strays, bare headers
      target     = items_sent + RANDOM_ITEMS;
      first_pass = 1'b1;
      while (items_sent < target) begin
         choice = $urandom_range(0, 11);
         if (first_pass ||
             (choice == 0 && items_sent + lpc_pkg::SAMPLES_PER_PACKET < target)) begin
            send_header();
            run_len    = lpc_pkg::SAMPLES_PER_PACKET + $urandom_range(0, 3);
            first_pass = 1'b0;
         end else if (choice == 1) begin
            run_len = $urandom_range(1, 4);
         end else if (choice == 2) begin
            send_header();
            run_len = 0;
         end else begin
            send_header();
            run_len = $urandom_range(1, 40);
         end
         repeat (run_len) send_sample();
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (16) @(posedge clock);

      $display("Ran %0d header and %0d sample requests through; %0d packet ends reached.",
               headers_seen, samples_seen, packet_ends);
      $display("Checked %0d results, %0d mismatches.", results_checked, failures);
      if (failures == 0 && outstanding == 0)
         $display("** lost_packet_crossfade: PASSED **");
      else
         $display("** lost_packet_crossfade: FAILED **");
      $finish;
   end

endmodule
